[hw/rtl/swrm_pkg.sv]
package swrm_pkg;

  localparam int unsigned PTS_W   = 48;
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned ARR_W   = 48;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned WT_W    = 32;

  // Shared divider geometry: widest dividend is span * 100 * 2^16, widest
  // divisor is arrival span * 9.
  localparam int unsigned DIV_NUM_W = 72;
  localparam int unsigned DIV_DEN_W = 52;
  localparam int unsigned DIV_REM_W = DIV_DEN_W + 1;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [WT_W-1:0] WINDOW_TICKS_RST = 32'd900000;

  // 8 bits per byte times 90000 ticks per second
  localparam logic [19:0] BPS_SCALE = 20'd720000;
  // 1e6 us per second times 2^16 is 15625 * 2^22
  localparam logic [13:0] FPS_SCALE = 14'd15625;
  localparam int unsigned FPS_SHIFT = 22;
  // pts ticks to us is 100/9, then 2^16 for Q16.16
  localparam logic [6:0]  SPD_SCALE = 7'd100;
  localparam int unsigned SPD_SHIFT = 16;

  typedef enum logic [1:0] {
    OP_BPS = 2'd0,
    OP_FPS = 2'd1,
    OP_SPD = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT_RD,
    ST_EVICT,
    ST_WRITE,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN
  } div_state_t;

endpackage

[hw/rtl/swrm_ram.sv]
module swrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/swrm_div.sv]
module swrm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [swrm_pkg::DIV_NUM_W-1:0] num,
  input  logic [swrm_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [swrm_pkg::RATE_W-1:0]    quo
);

  swrm_pkg::div_state_t state_r, state_nxt;
  logic [swrm_pkg::DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [swrm_pkg::DIV_DEN_W-1:0] den_r, den_nxt;
  logic [31:0]                    lo_r, lo_nxt;
  logic [swrm_pkg::RATE_W-1:0]    quo_r, quo_nxt;
  logic [swrm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [swrm_pkg::DIV_REM_W-1:0] trial;
  logic                           fits;
  logic                           sat;
  logic                           last;

  // trial remainder: shift in the next dividend bit
  assign trial = {rem_r[swrm_pkg::DIV_REM_W-2:0], lo_r[31]};
  assign fits  = trial >= {1'b0, den_r};
  // quotient overflows 32 bits when the upper dividend part reaches the divisor
  assign sat   = rem_r >= {1'b0, den_r};
  assign last  = cnt_r == {swrm_pkg::DIV_CNT_W{1'b1}};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrm_pkg::DV_IDLE: begin
        if (start) begin
          state_nxt = swrm_pkg::DV_CHECK;
        end
      end
      swrm_pkg::DV_CHECK: begin
        state_nxt = sat ? swrm_pkg::DV_IDLE : swrm_pkg::DV_RUN;
      end
      swrm_pkg::DV_RUN: begin
        if (last) begin
          state_nxt = swrm_pkg::DV_IDLE;
        end
      end
      default: state_nxt = swrm_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    lo_nxt  = lo_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    case (state_r)
      swrm_pkg::DV_IDLE: begin
        if (start) begin
          rem_nxt = swrm_pkg::DIV_REM_W'(num[swrm_pkg::DIV_NUM_W-1:32]);
          lo_nxt  = num[31:0];
          den_nxt = den;
          cnt_nxt = '0;
        end
      end
      swrm_pkg::DV_RUN: begin
        rem_nxt = fits ? trial - {1'b0, den_r} : trial;
        lo_nxt  = {lo_r[30:0], 1'b0};
        quo_nxt = {quo_r[swrm_pkg::RATE_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done = 1'b0;
    quo  = quo_nxt;
    case (state_r)
      swrm_pkg::DV_CHECK: begin
        done = sat;
        quo  = '1;
      end
      swrm_pkg::DV_RUN: begin
        done = last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swrm_pkg::DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

[hw/rtl/sliding_window_rate_meter.sv]
// Sliding-window rate meter. Each input word is one media frame (90 kHz pts,
// byte size, arrival time in us). The frame is stored in a ring of RING_DEPTH
// entries and added to a window byte sum; a full ring evicts its oldest entry
// first. Entries whose pts lies window_ticks or more behind the new frame are
// then dropped oldest first, always keeping the newest. With two or more
// entries and nonzero pts and arrival spans, bit rate, frame rate (Q16.16) and
// speed ratio (Q16.16) are recomputed through one shared radix-2 divider, all
// saturated to 32 bits; otherwise the last values are held. One result word
// per input word. Per frame, from acceptance the sequencer steps through ring
// bookkeeping (accept, write, first read of the oldest entry, load of the
// output register), plus a read and an eviction when the ring is full, plus
// a check and a re-read per dropped entry, plus a check of the entry that
// stays when two or more remain, plus three divisions when the rates are
// recomputed (operand setup, overflow check and 32 quotient bits per
// division; a saturating division ends after the check). The ring is a
// single-port-read memory with registered read, hence the re-read per drop.
// A stalled output register holds the sequencer in its output state.
// Input stall is high from acceptance until the result has been placed in
// the output register; window_ticks may only be written while no frame is in
// flight.
module sliding_window_rate_meter #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_wr_en,
  input  logic [swrm_pkg::WT_W-1:0]     cfg_wr_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swrm_pkg::PTS_W-1:0]    in_frame_pts,
  input  logic [swrm_pkg::BYTES_W-1:0]  in_frame_bytes,
  input  logic [swrm_pkg::ARR_W-1:0]    in_arrival_us,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swrm_pkg::PTS_W-1:0]    out_frames_seen,
  output logic [swrm_pkg::RATE_W-1:0]   out_bits_per_second,
  output logic [swrm_pkg::RATE_W-1:0]   out_frames_per_second,
  output logic [swrm_pkg::RATE_W-1:0]   out_speed_ratio,
  output logic [swrm_pkg::PTS_W-1:0]    out_pts_elapsed,
  output logic                          out_rates_updated
);

  localparam int unsigned AW     = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W  = swrm_pkg::BYTES_W + AW;
  localparam int unsigned ENT_W  = swrm_pkg::PTS_W + swrm_pkg::ARR_W + swrm_pkg::BYTES_W;
  localparam int unsigned BPS_PW = SUM_W + 20;
  localparam int unsigned FPS_PW = CNT_W + 14;
  localparam int unsigned SPD_PW = swrm_pkg::PTS_W + 7;

  swrm_pkg::state_t state_r, state_nxt;

  logic [swrm_pkg::WT_W-1:0]    wt_r, wt_nxt;
  logic [swrm_pkg::PTS_W-1:0]   pts_r, pts_nxt;
  logic [swrm_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [swrm_pkg::ARR_W-1:0]   arr_r, arr_nxt;
  logic [AW-1:0]                newest_r, newest_nxt;
  logic [AW-1:0]                oldest_r, oldest_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [swrm_pkg::PTS_W-1:0]   first_pts_r, first_pts_nxt;
  logic [swrm_pkg::PTS_W-1:0]   total_r, total_nxt;
  logic [swrm_pkg::RATE_W-1:0]  bps_r, bps_nxt;
  logic [swrm_pkg::RATE_W-1:0]  fps_r, fps_nxt;
  logic [swrm_pkg::RATE_W-1:0]  spd_r, spd_nxt;
  logic [swrm_pkg::PTS_W-1:0]   elapsed_r, elapsed_nxt;
  logic                         upd_r, upd_nxt;
  logic [swrm_pkg::PTS_W-1:0]   dp_r, dp_nxt;
  logic [swrm_pkg::ARR_W-1:0]   dt_r, dt_nxt;
  swrm_pkg::op_t                op_r, op_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [swrm_pkg::PTS_W-1:0]   o_seen_r, o_seen_nxt;
  logic [swrm_pkg::RATE_W-1:0]  o_bps_r, o_bps_nxt;
  logic [swrm_pkg::RATE_W-1:0]  o_fps_r, o_fps_nxt;
  logic [swrm_pkg::RATE_W-1:0]  o_spd_r, o_spd_nxt;
  logic [swrm_pkg::PTS_W-1:0]   o_elapsed_r, o_elapsed_nxt;
  logic                         o_upd_r, o_upd_nxt;

  // ring access
  logic                         mem_wr_en;
  logic                         mem_rd_en;
  logic [ENT_W-1:0]             mem_wr_data;
  logic [ENT_W-1:0]             mem_rd_data;
  logic [swrm_pkg::PTS_W-1:0]   rd_pts;
  logic [swrm_pkg::ARR_W-1:0]   rd_arr;
  logic [swrm_pkg::BYTES_W-1:0] rd_bytes;

  // shared divider
  logic                              div_start;
  logic [swrm_pkg::DIV_NUM_W-1:0]    div_num;
  logic [swrm_pkg::DIV_DEN_W-1:0]    div_den;
  logic                              div_done;
  logic [swrm_pkg::RATE_W-1:0]       div_quo;

  logic                         accept;
  logic                         out_free;
  logic                         ring_full;
  logic [AW-1:0]                newest_inc;
  logic [AW-1:0]                oldest_inc;
  logic [swrm_pkg::PTS_W-1:0]   age;
  logic [swrm_pkg::ARR_W-1:0]   arr_span;
  logic                         drop;
  logic                         spans_ok;
  logic [BPS_PW-1:0]            bps_prod;
  logic [FPS_PW-1:0]            fps_prod;
  logic [SPD_PW-1:0]            spd_prod;

  assign accept    = (state_r == swrm_pkg::ST_IDLE) && in_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign ring_full = count_r == CNT_W'(RING_DEPTH);

  // wrap the slot pointers at the ring depth
  assign newest_inc = (newest_r == AW'(RING_DEPTH - 1)) ? '0 : newest_r + 1'b1;
  assign oldest_inc = (oldest_r == AW'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  assign mem_wr_data = {pts_r, arr_r, bytes_r};
  assign rd_pts   = mem_rd_data[ENT_W-1 -: swrm_pkg::PTS_W];
  assign rd_arr   = mem_rd_data[swrm_pkg::BYTES_W +: swrm_pkg::ARR_W];
  assign rd_bytes = mem_rd_data[swrm_pkg::BYTES_W-1:0];

  // spans against the oldest entry, both modulo 2^48
  assign age      = pts_r - rd_pts;
  assign arr_span = arr_r - rd_arr;
  assign drop     = age >= swrm_pkg::PTS_W'(wt_r);
  assign spans_ok = (age != '0) && (arr_span != '0);

  // constant-scaled dividends
  assign bps_prod = BPS_PW'(sum_r) * BPS_PW'(swrm_pkg::BPS_SCALE);
  assign fps_prod = FPS_PW'(count_r) * FPS_PW'(swrm_pkg::FPS_SCALE);
  assign spd_prod = SPD_PW'(dp_r) * SPD_PW'(swrm_pkg::SPD_SCALE);

  always_comb begin
    case (op_r)
      swrm_pkg::OP_BPS: begin
        div_num = swrm_pkg::DIV_NUM_W'(bps_prod);
        div_den = swrm_pkg::DIV_DEN_W'(dp_r);
      end
      swrm_pkg::OP_FPS: begin
        div_num = swrm_pkg::DIV_NUM_W'({fps_prod, {swrm_pkg::FPS_SHIFT{1'b0}}});
        div_den = swrm_pkg::DIV_DEN_W'(dt_r);
      end
      swrm_pkg::OP_SPD: begin
        div_num = swrm_pkg::DIV_NUM_W'({spd_prod, {swrm_pkg::SPD_SHIFT{1'b0}}});
        // arrival span times nine
        div_den = swrm_pkg::DIV_DEN_W'({dt_r, 3'b000}) + swrm_pkg::DIV_DEN_W'(dt_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (count_r != '0 && ring_full) ? swrm_pkg::ST_EVICT_RD
                                                   : swrm_pkg::ST_WRITE;
        end
      end
      swrm_pkg::ST_EVICT_RD:  state_nxt = swrm_pkg::ST_EVICT;
      swrm_pkg::ST_EVICT:     state_nxt = swrm_pkg::ST_WRITE;
      swrm_pkg::ST_WRITE:     state_nxt = swrm_pkg::ST_DRAIN_RD;
      swrm_pkg::ST_DRAIN_RD: begin
        state_nxt = (count_r > CNT_W'(1)) ? swrm_pkg::ST_DRAIN_CHK : swrm_pkg::ST_OUT;
      end
      swrm_pkg::ST_DRAIN_CHK: begin
        if (drop) begin
          state_nxt = swrm_pkg::ST_DRAIN_RD;
        end else begin
          state_nxt = spans_ok ? swrm_pkg::ST_PREP : swrm_pkg::ST_OUT;
        end
      end
      swrm_pkg::ST_PREP:      state_nxt = swrm_pkg::ST_DIV;
      swrm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = (op_r == swrm_pkg::OP_SPD) ? swrm_pkg::ST_OUT : swrm_pkg::ST_PREP;
        end
      end
      swrm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = swrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swrm_pkg::ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    div_start = 1'b0;
    case (state_r)
      swrm_pkg::ST_IDLE:     in_stall  = 1'b0;
      swrm_pkg::ST_EVICT_RD: mem_rd_en = 1'b1;
      swrm_pkg::ST_WRITE:    mem_wr_en = 1'b1;
      swrm_pkg::ST_DRAIN_RD: mem_rd_en = 1'b1;
      swrm_pkg::ST_PREP:     div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath updates
  always_comb begin
    wt_nxt        = cfg_wr_en ? cfg_wr_data : wt_r;
    pts_nxt       = pts_r;
    bytes_nxt     = bytes_r;
    arr_nxt       = arr_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    first_pts_nxt = first_pts_r;
    total_nxt     = total_r;
    bps_nxt       = bps_r;
    fps_nxt       = fps_r;
    spd_nxt       = spd_r;
    elapsed_nxt   = elapsed_r;
    upd_nxt       = upd_r;
    dp_nxt        = dp_r;
    dt_nxt        = dt_r;
    op_nxt        = op_r;
    o_seen_nxt    = o_seen_r;
    o_bps_nxt     = o_bps_r;
    o_fps_nxt     = o_fps_r;
    o_spd_nxt     = o_spd_r;
    o_elapsed_nxt = o_elapsed_r;
    o_upd_nxt     = o_upd_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      swrm_pkg::ST_IDLE: begin
        if (accept) begin
          pts_nxt   = in_frame_pts;
          bytes_nxt = in_frame_bytes;
          arr_nxt   = in_arrival_us;
          total_nxt = total_r + 1'b1;
          upd_nxt   = 1'b0;
          if (count_r == '0) begin
            // empty window: restart at the oldest slot
            first_pts_nxt = in_frame_pts;
            newest_nxt    = oldest_r;
          end else if (!ring_full) begin
            newest_nxt = newest_inc;
          end
        end
      end
      swrm_pkg::ST_EVICT: begin
        // ring full: drop the oldest to make room
        sum_nxt    = sum_r - SUM_W'(rd_bytes);
        oldest_nxt = oldest_inc;
        count_nxt  = count_r - 1'b1;
        newest_nxt = newest_inc;
      end
      swrm_pkg::ST_WRITE: begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + SUM_W'(bytes_r);
      end
      swrm_pkg::ST_DRAIN_CHK: begin
        if (drop) begin
          sum_nxt    = sum_r - SUM_W'(rd_bytes);
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
        end else begin
          elapsed_nxt = pts_r - first_pts_r;
          dp_nxt      = age;
          dt_nxt      = arr_span;
          op_nxt      = swrm_pkg::OP_BPS;
          upd_nxt     = spans_ok;
        end
      end
      swrm_pkg::ST_DIV: begin
        if (div_done) begin
          case (op_r)
            swrm_pkg::OP_BPS: begin
              bps_nxt = div_quo;
              op_nxt  = swrm_pkg::OP_FPS;
            end
            swrm_pkg::OP_FPS: begin
              fps_nxt = div_quo;
              op_nxt  = swrm_pkg::OP_SPD;
            end
            default: spd_nxt = div_quo;
          endcase
        end
      end
      swrm_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_seen_nxt    = total_r;
          o_bps_nxt     = bps_r;
          o_fps_nxt     = fps_r;
          o_spd_nxt     = spd_r;
          o_elapsed_nxt = elapsed_r;
          o_upd_nxt     = upd_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrm_pkg::ST_IDLE;
      wt_r        <= swrm_pkg::WINDOW_TICKS_RST;
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      first_pts_r <= '0;
      total_r     <= '0;
      bps_r       <= '0;
      fps_r       <= '0;
      spd_r       <= '0;
      elapsed_r   <= '0;
      upd_r       <= 1'b0;
      op_r        <= swrm_pkg::OP_BPS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wt_r        <= wt_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      first_pts_r <= first_pts_nxt;
      total_r     <= total_nxt;
      bps_r       <= bps_nxt;
      fps_r       <= fps_nxt;
      spd_r       <= spd_nxt;
      elapsed_r   <= elapsed_nxt;
      upd_r       <= upd_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pts_r       <= pts_nxt;
    bytes_r     <= bytes_nxt;
    arr_r       <= arr_nxt;
    dp_r        <= dp_nxt;
    dt_r        <= dt_nxt;
    o_seen_r    <= o_seen_nxt;
    o_bps_r     <= o_bps_nxt;
    o_fps_r     <= o_fps_nxt;
    o_spd_r     <= o_spd_nxt;
    o_elapsed_r <= o_elapsed_nxt;
    o_upd_r     <= o_upd_nxt;
  end

  swrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (newest_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (oldest_r),
    .rd_data (mem_rd_data)
  );

  swrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid             = out_valid_r;
  assign out_frames_seen       = o_seen_r;
  assign out_bits_per_second   = o_bps_r;
  assign out_frames_per_second = o_fps_r;
  assign out_speed_ratio       = o_spd_r;
  assign out_pts_elapsed       = o_elapsed_r;
  assign out_rates_updated     = o_upd_r;

endmodule

[hw/rtl/swrm_chk.sv]
module swrm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [swrm_pkg::PTS_W-1:0]    out_frames_seen,
  input logic [swrm_pkg::RATE_W-1:0]   out_bits_per_second
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frames_seen)
                                  && $stable(out_bits_per_second)))
    else $error("stalled result word changed");

  // one word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // a result never appears in the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result word too early");

endmodule

bind sliding_window_rate_meter swrm_chk u_swrm_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_frames_seen     (out_frames_seen),
  .out_bits_per_second (out_bits_per_second)
);
